/* rtl/sap_pkg.sv */
`timescale 1ns / 1ps

package sap_pkg;

    // page geometry and capacity
    localparam int PAGE_WIDTH   = 1024;
    localparam int PAGE_HEIGHT  = 1024;
    localparam int MAX_PAGES    = 4;
    localparam int MAX_SHELVES  = 64;
    localparam int HEIGHT_ALIGN = 4;

    // field widths
    localparam int DIM_W    = 11;
    localparam int MARGIN_W = 10;
    localparam int STATUS_W = 2;

    // derived widths
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int PCNT_W     = $clog2(MAX_PAGES + 1);
    localparam int SHELF_W    = $clog2(MAX_SHELVES);
    localparam int SCNT_W     = $clog2(MAX_SHELVES + 1);
    localparam int SLOT_W     = PAGE_W + SHELF_W;
    localparam int SLOTS      = MAX_PAGES * MAX_SHELVES;
    localparam int ALIGN_W    = $clog2(HEIGHT_ALIGN);

    // request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PLACED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // classified request handed from front to back
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             oversize;
    } cmd_t;

endpackage

/* rtl/shelf_atlas_allocator.sv */
`timescale 1ns / 1ps

// shelf packing allocator for fixed-size atlas pages
// request channel: push with req_width / req_height, taken when full is low;
//   the height is rounded up to a multiple of 4
// result channel: status, page_index, place_x, place_y, shelf_height,
//   opened_shelf, opened_page are valid while empty is low, retired by pop
// one result per request, in request order
// configuration: cfg_we writes cfg_wdata into top_margin, the first shelf
//   row of a fresh page; write it only while no request is in flight
// search: the back end scans the S open shelves for one of exactly this height,
//   one shelf read per cycle through the store's single read port, then tries
//   each of the P open pages for a new shelf; it serves one request at a
//   time, so the next waits in the queue until this one retires; oversize
//   requests skip the search and go straight to the retire step
// a four-entry request queue keeps accepting while the back end scans or
//   while a finished result waits; a stalled result holds the back end only
//   at its final retire step
// reset empties the atlas (no pages, no shelves) and clears top_margin;
//   the shelf store itself needs no clearing pass
module shelf_atlas_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [sap_pkg::DIM_W-1:0]      req_width,
    input  logic [sap_pkg::DIM_W-1:0]      req_height,
    output logic                           empty,
    input  logic                           pop,
    output logic [sap_pkg::STATUS_W-1:0]   status,
    output logic [sap_pkg::PAGE_W-1:0]     page_index,
    output logic [sap_pkg::DIM_W-1:0]      place_x,
    output logic [sap_pkg::MARGIN_W-1:0]   place_y,
    output logic [sap_pkg::DIM_W-1:0]      shelf_height,
    output logic                           opened_shelf,
    output logic                           opened_page,
    input  logic                           cfg_we,
    input  logic [sap_pkg::MARGIN_W-1:0]   cfg_wdata
);

    import sap_pkg::*;

    logic [MARGIN_W-1:0] top_margin_reg;
    logic                cmd_valid;
    logic                cmd_pop;
    cmd_t                cmd;

    // top margin register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_margin_reg <= '0;
        end
        else if (cfg_we)
        begin
            top_margin_reg <= cfg_wdata;
        end
    end

    // request intake and classification
    sap_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_width  (req_width),
        .req_height (req_height),
        .top_margin (top_margin_reg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    // shelf search and store update
    sap_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .top_margin   (top_margin_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .page_index   (page_index),
        .place_x      (place_x),
        .place_y      (place_y),
        .shelf_height (shelf_height),
        .opened_shelf (opened_shelf),
        .opened_page  (opened_page)
    );

endmodule

/* rtl/sap_ram.sv */
`timescale 1ns / 1ps

module sap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/sap_front.sv */
`timescale 1ns / 1ps

module sap_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [sap_pkg::DIM_W-1:0]      req_width,
    input  logic [sap_pkg::DIM_W-1:0]      req_height,
    input  logic [sap_pkg::MARGIN_W-1:0]   top_margin,
    output logic                           cmd_valid,
    output sap_pkg::cmd_t                  cmd,
    input  logic                           cmd_pop
);

    import sap_pkg::*;

    cmd_t                q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push_ok;
    logic [DIM_W:0]      h_sum;
    logic [DIM_W:0]      h_round;
    logic [DIM_W+1:0]    h_span;
    cmd_t                cmd_in;

    // round height up to the alignment and flag requests that never fit
    always_comb
    begin
        h_sum   = {1'b0, req_height} + (DIM_W+1)'(HEIGHT_ALIGN - 1);
        h_round = {h_sum[DIM_W:ALIGN_W], {ALIGN_W{1'b0}}};
        h_span  = (DIM_W+2)'(top_margin) + {1'b0, h_round};
        cmd_in.width    = req_width;
        cmd_in.height   = h_round[DIM_W-1:0];
        cmd_in.oversize = (req_width > DIM_W'(PAGE_WIDTH))
                       || (h_span > (DIM_W+2)'(PAGE_HEIGHT));
    end

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push_ok   = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    // queue occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push_ok && !cmd_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!push_ok && cmd_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("request queue overfilled");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (count_reg != '0))
        else $error("request taken from empty queue");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push_ok && !cmd_pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("request queue lost a request");

endmodule

/* rtl/sap_back.sv */
`timescale 1ns / 1ps

module sap_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [sap_pkg::MARGIN_W-1:0]   top_margin,
    input  logic                           cmd_valid,
    input  sap_pkg::cmd_t                  cmd,
    output logic                           cmd_pop,
    output logic                           empty,
    input  logic                           pop,
    output logic [sap_pkg::STATUS_W-1:0]   status,
    output logic [sap_pkg::PAGE_W-1:0]     page_index,
    output logic [sap_pkg::DIM_W-1:0]      place_x,
    output logic [sap_pkg::MARGIN_W-1:0]   place_y,
    output logic [sap_pkg::DIM_W-1:0]      shelf_height,
    output logic                           opened_shelf,
    output logic                           opened_page
);

    import sap_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_NS_ISSUE = 3'd2;
    localparam logic [2:0] S_NS_CHK   = 3'd3;
    localparam logic [2:0] S_PAGE     = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    // store update to perform when the result retires
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_HIT   = 2'd1;
    localparam logic [1:0] ACT_SHELF = 2'd2;
    localparam logic [1:0] ACT_PAGE  = 2'd3;

    logic [2:0]          state_reg, state_next;
    logic [DIM_W-1:0]    w_reg, w_next;
    logic [DIM_W-1:0]    h_reg, h_next;
    logic [PCNT_W-1:0]   p_reg, p_next;
    logic [SHELF_W-1:0]  s_reg, s_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [SLOT_W-1:0]   chk_slot_reg, chk_slot_next;
    logic                use_margin_reg, use_margin_next;
    logic [1:0]          act_reg, act_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [DIM_W-1:0]    x_reg, x_next;
    logic [DIM_W-1:0]    y_reg, y_next;
    logic [PCNT_W-1:0]   pages_reg, pages_next;
    logic [SCNT_W-1:0]   spp_reg [MAX_PAGES];
    logic [SCNT_W-1:0]   spp_next [MAX_PAGES];

    logic                res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0] res_status_reg;
    logic [PAGE_W-1:0]   res_page_reg;
    logic [DIM_W-1:0]    res_x_reg;
    logic [MARGIN_W-1:0] res_y_reg;
    logic [DIM_W-1:0]    res_h_reg;
    logic                res_os_reg;
    logic                res_op_reg;

    logic [PAGE_W-1:0]   p_idx;
    logic [SCNT_W-1:0]   n_cur;
    logic [SHELF_W-1:0]  n_last;
    logic [SLOT_W-1:0]   rd_addr;
    logic [DIM_W-1:0]    ht_rd, top_rd, fill_rd;
    logic                issue;
    logic                scan_done;
    logic                match;
    logic [DIM_W:0]      y_calc;
    logic                fits;
    logic                res_free;
    logic                res_load;
    logic                shelf_we, fill_we;
    logic [DIM_W-1:0]    fill_wdata;

    // shelf stores
    sap_ram #(.WIDTH(DIM_W), .DEPTH(SLOTS)) u_height_ram (
        .clk   (clk),
        .we    (shelf_we),
        .waddr (slot_reg),
        .wdata (h_reg),
        .raddr (rd_addr),
        .rdata (ht_rd)
    );

    sap_ram #(.WIDTH(DIM_W), .DEPTH(SLOTS)) u_top_ram (
        .clk   (clk),
        .we    (shelf_we),
        .waddr (slot_reg),
        .wdata (y_reg),
        .raddr (rd_addr),
        .rdata (top_rd)
    );

    sap_ram #(.WIDTH(DIM_W), .DEPTH(SLOTS)) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (slot_reg),
        .wdata (fill_wdata),
        .raddr (rd_addr),
        .rdata (fill_rd)
    );

    // current page and its shelf count
    always_comb
    begin
        p_idx     = p_reg[PAGE_W-1:0];
        n_cur     = spp_reg[p_idx];
        n_last    = n_cur[SHELF_W-1:0] - SHELF_W'(1);
        issue     = (p_reg < pages_reg) && (SCNT_W'(s_reg) < n_cur);
        scan_done = (p_reg >= pages_reg);
        rd_addr   = (state_reg == S_SCAN) ? {p_idx, s_reg} : {p_idx, n_last};
    end

    // exact-height shelf with room, and new shelf under the last one
    always_comb
    begin
        match  = chk_valid_reg && (ht_rd == h_reg)
              && (({1'b0, fill_rd} + {1'b0, w_reg}) <= (DIM_W+1)'(PAGE_WIDTH));
        y_calc = use_margin_reg ? (DIM_W+1)'(top_margin)
                                : ({1'b0, top_rd} + {1'b0, ht_rd});
        fits   = ((DIM_W+2)'(y_calc) + (DIM_W+2)'(h_reg)) <= (DIM_W+2)'(PAGE_HEIGHT);
    end

    // result register handshake
    assign res_free = !res_valid_reg || pop;
    assign res_load = (state_reg == S_DONE) && res_free;
    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;

    // store writes at retire
    always_comb
    begin
        shelf_we   = res_load && ((act_reg == ACT_SHELF) || (act_reg == ACT_PAGE));
        fill_we    = res_load && (act_reg != ACT_NONE);
        fill_wdata = (act_reg == ACT_HIT) ? (x_reg + w_reg) : w_reg;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        p_next          = p_reg;
        s_next          = s_reg;
        chk_valid_next  = 1'b0;
        chk_slot_next   = chk_slot_reg;
        use_margin_next = use_margin_reg;
        act_next        = act_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        page_next       = page_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        pages_next      = pages_reg;
        for (int i = 0; i < MAX_PAGES; i++)
        begin
            spp_next[i] = spp_reg[i];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    w_next      = cmd.width;
                    h_next      = cmd.height;
                    p_next      = '0;
                    s_next      = '0;
                    act_next    = ACT_NONE;
                    status_next = cmd.oversize ? ST_OVERSIZE : ST_PLACED;
                    state_next  = cmd.oversize ? S_DONE : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue one shelf read per cycle, check the previous one
                chk_valid_next = issue;
                chk_slot_next  = {p_idx, s_reg};
                if (!scan_done)
                begin
                    if (issue && ((SCNT_W'(s_reg) + SCNT_W'(1)) < n_cur))
                    begin
                        s_next = s_reg + SHELF_W'(1);
                    end
                    else
                    begin
                        p_next = p_reg + PCNT_W'(1);
                        s_next = '0;
                    end
                end
                if (match)
                begin
                    chk_valid_next = 1'b0;
                    act_next       = ACT_HIT;
                    slot_next      = chk_slot_reg;
                    page_next      = chk_slot_reg[SLOT_W-1 -: PAGE_W];
                    x_next         = fill_rd;
                    y_next         = top_rd;
                    state_next     = S_DONE;
                end
                else if (scan_done && !chk_valid_reg)
                begin
                    p_next     = '0;
                    state_next = S_NS_ISSUE;
                end
            end

            S_NS_ISSUE:
            begin
                if (scan_done)
                begin
                    state_next = S_PAGE;
                end
                else if (n_cur == SCNT_W'(MAX_SHELVES))
                begin
                    p_next = p_reg + PCNT_W'(1);
                end
                else
                begin
                    use_margin_next = (n_cur == '0);
                    state_next      = S_NS_CHK;
                end
            end

            S_NS_CHK:
            begin
                if (fits)
                begin
                    act_next   = ACT_SHELF;
                    slot_next  = {p_idx, n_cur[SHELF_W-1:0]};
                    page_next  = p_idx;
                    x_next     = '0;
                    y_next     = y_calc[DIM_W-1:0];
                    state_next = S_DONE;
                end
                else
                begin
                    p_next     = p_reg + PCNT_W'(1);
                    state_next = S_NS_ISSUE;
                end
            end

            S_PAGE:
            begin
                if (pages_reg == PCNT_W'(MAX_PAGES))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    act_next  = ACT_PAGE;
                    page_next = pages_reg[PAGE_W-1:0];
                    slot_next = {pages_reg[PAGE_W-1:0], {SHELF_W{1'b0}}};
                    x_next    = '0;
                    y_next    = DIM_W'(top_margin);
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_free)
                begin
                    if ((act_reg == ACT_SHELF) || (act_reg == ACT_PAGE))
                    begin
                        spp_next[page_reg] = spp_reg[page_reg] + SCNT_W'(1);
                    end
                    if (act_reg == ACT_PAGE)
                    begin
                        pages_next = pages_reg + PCNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_valid_next = (res_valid_reg && !pop) || res_load;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chk_valid_reg <= 1'b0;
            pages_reg     <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_PAGES; i++)
            begin
                spp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            pages_reg     <= pages_next;
            res_valid_reg <= res_valid_next;
            for (int i = 0; i < MAX_PAGES; i++)
            begin
                spp_reg[i] <= spp_next[i];
            end
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        w_reg          <= w_next;
        h_reg          <= h_next;
        p_reg          <= p_next;
        s_reg          <= s_next;
        chk_slot_reg   <= chk_slot_next;
        use_margin_reg <= use_margin_next;
        act_reg        <= act_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
        page_reg       <= page_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
    end

    // result register, failed requests report zeros
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_status_reg <= status_reg;
            if (act_reg == ACT_NONE)
            begin
                res_page_reg <= '0;
                res_x_reg    <= '0;
                res_y_reg    <= '0;
                res_h_reg    <= '0;
                res_os_reg   <= 1'b0;
                res_op_reg   <= 1'b0;
            end
            else
            begin
                res_page_reg <= page_reg;
                res_x_reg    <= x_reg;
                res_y_reg    <= y_reg[MARGIN_W-1:0];
                res_h_reg    <= h_reg;
                res_os_reg   <= (act_reg != ACT_HIT);
                res_op_reg   <= (act_reg == ACT_PAGE);
            end
        end
    end

    assign empty        = !res_valid_reg;
    assign status       = res_status_reg;
    assign page_index   = res_page_reg;
    assign place_x      = res_x_reg;
    assign place_y      = res_y_reg;
    assign shelf_height = res_h_reg;
    assign opened_shelf = res_os_reg;
    assign opened_page  = res_op_reg;

    a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pages_reg <= PCNT_W'(MAX_PAGES))
        else $error("page count beyond capacity");

    a_hit_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && act_reg == ACT_HIT)
        |-> (({1'b0, x_reg} + {1'b0, w_reg}) <= (DIM_W+1)'(PAGE_WIDTH)))
        else $error("placement runs past page edge");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_status_reg != ST_PLACED)
        |-> (res_page_reg == '0 && res_x_reg == '0 && res_y_reg == '0
             && res_h_reg == '0 && !res_os_reg && !res_op_reg))
        else $error("failed request carries placement data");

    a_page_has_shelf: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_op_reg) |-> res_os_reg)
        else $error("new page without new shelf");

endmodule

/* dv/shelf_atlas_checker.sv */
`timescale 1ns / 1ps

module shelf_atlas_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           full,
    input  logic [sap_pkg::DIM_W-1:0]      req_width,
    input  logic [sap_pkg::DIM_W-1:0]      req_height,
    input  logic                           empty,
    input  logic                           pop,
    input  logic [sap_pkg::STATUS_W-1:0]   status,
    input  logic [sap_pkg::PAGE_W-1:0]     page_index,
    input  logic [sap_pkg::DIM_W-1:0]      place_x,
    input  logic [sap_pkg::MARGIN_W-1:0]   place_y,
    input  logic [sap_pkg::DIM_W-1:0]      shelf_height,
    input  logic                           opened_shelf,
    input  logic                           opened_page,
    input  logic                           cfg_we,
    input  logic [sap_pkg::MARGIN_W-1:0]   cfg_wdata,
    output int                             fail_count,
    output int                             pending,
    output int                             n_placed,
    output int                             n_oversize,
    output int                             n_full
);

    import sap_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page;
        logic [DIM_W-1:0]    x;
        logic [MARGIN_W-1:0] y;
        logic [DIM_W-1:0]    height;
        logic                new_shelf;
        logic                new_page;
    } placement_t;

    // local copy of the atlas: shelf tops kept wide so a shelf at the page bottom
    // still chains correctly
    logic [MARGIN_W-1:0] margin;
    logic [DIM_W-1:0]    shelf_h    [SLOTS];
    logic [DIM_W-1:0]    shelf_top  [SLOTS];
    logic [DIM_W-1:0]    shelf_fill [SLOTS];
    logic [SCNT_W-1:0]   shelf_count [MAX_PAGES];
    logic [PCNT_W-1:0]   pages_used;

    placement_t placement_q [$];

    // append a shelf to a page
    function automatic void open_shelf(input int pg, input int y, input int h);
        int idx;
        idx = pg * MAX_SHELVES + int'(shelf_count[pg]);
        shelf_h[idx]    = DIM_W'(h);
        shelf_top[idx]  = DIM_W'(y);
        shelf_fill[idx] = '0;
        shelf_count[pg] = shelf_count[pg] + 1'b1;
    endfunction

    // where the atlas puts one rectangle, and the atlas update it causes
    function automatic placement_t place_rect(input logic [DIM_W-1:0] w_in,
                                              input logic [DIM_W-1:0] h_in);
        placement_t r;
        int w, h, y, n, idx, slot, pg;
        bit found;
        r = '0;
        w = int'(w_in);
        h = ((int'(h_in) + HEIGHT_ALIGN - 1) / HEIGHT_ALIGN) * HEIGHT_ALIGN;
        slot = 0;
        pg = 0;
        found = 1'b0;

        // never fits, even on an empty page
        if (w > PAGE_WIDTH || int'(margin) + h > PAGE_HEIGHT) begin
            r.status = ST_OVERSIZE;
            return r;
        end

        // first shelf of exactly this height with width left
        for (int p = 0; p < int'(pages_used) && !found; p++) begin
            for (int s = 0; s < int'(shelf_count[p]) && !found; s++) begin
                idx = p * MAX_SHELVES + s;
                if (int'(shelf_h[idx]) == h && PAGE_WIDTH - int'(shelf_fill[idx]) >= w) begin
                    slot = idx;
                    pg = p;
                    found = 1'b1;
                end
            end
        end

        // new shelf under the last one of the first page with room
        for (int p = 0; p < int'(pages_used) && !found; p++) begin
            n = int'(shelf_count[p]);
            if (n < MAX_SHELVES) begin
                y = int'(margin);
                if (n > 0) begin
                    idx = p * MAX_SHELVES + n - 1;
                    y = int'(shelf_top[idx]) + int'(shelf_h[idx]);
                end
                if (y <= PAGE_HEIGHT && PAGE_HEIGHT - y >= h) begin
                    slot = p * MAX_SHELVES + n;
                    open_shelf(p, y, h);
                    pg = p;
                    r.new_shelf = 1'b1;
                    found = 1'b1;
                end
            end
        end

        // fresh page, or the atlas is full
        if (!found) begin
            if (int'(pages_used) >= MAX_PAGES) begin
                r.status = ST_FULL;
                return r;
            end
            pg = int'(pages_used);
            pages_used = pages_used + 1'b1;
            shelf_count[pg] = '0;
            slot = pg * MAX_SHELVES;
            open_shelf(pg, int'(margin), h);
            r.new_shelf = 1'b1;
            r.new_page = 1'b1;
        end

        r.status = ST_PLACED;
        r.page   = PAGE_W'(pg);
        r.x      = shelf_fill[slot];
        r.y      = shelf_top[slot][MARGIN_W-1:0];
        r.height = shelf_h[slot];
        shelf_fill[slot] = shelf_fill[slot] + DIM_W'(w);
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // results first, then new requests, then register writes
    always @(posedge clk or negedge rst_n) begin
        placement_t want;
        if (!rst_n) begin
            margin = '0;
            pages_used = '0;
            foreach (shelf_count[i])
                shelf_count[i] = '0;
            placement_q.delete();
            fail_count = 0;
            pending = 0;
            n_placed = 0;
            n_oversize = 0;
            n_full = 0;
        end
        else begin
            // retire the oldest expectation
            if (pop && !empty) begin
                if (placement_q.size() == 0) begin
                    $error("result popped with no request outstanding");
                    fail_count++;
                end
                else begin
                    want = placement_q.pop_front();
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("page_index", 32'(want.page), 32'(page_index));
                    compare_field("place_x", 32'(want.x), 32'(place_x));
                    compare_field("place_y", 32'(want.y), 32'(place_y));
                    compare_field("shelf_height", 32'(want.height), 32'(shelf_height));
                    compare_field("opened_shelf", 32'(want.new_shelf), 32'(opened_shelf));
                    compare_field("opened_page", 32'(want.new_page), 32'(opened_page));
                    case (want.status)
                        ST_PLACED:   n_placed++;
                        ST_OVERSIZE: n_oversize++;
                        default:     n_full++;
                    endcase
                end
            end

            // accepted request
            if (push && !full)
                placement_q.push_back(place_rect(req_width, req_height));

            // register write
            if (cfg_we)
                margin = cfg_wdata;

            pending = placement_q.size();
        end
    end

endmodule

/* dv/shelf_atlas_allocator_test.sv */
`timescale 1ns / 1ps

module shelf_atlas_allocator_test;
    import sap_pkg::*;

    localparam int RANDOM_REQS  = 1050;
    localparam int IDLE_PCT     = 24;
    localparam int CALM_FROM    = 400;
    localparam int CALM_TO      = 600;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 2500;
    localparam int DRAIN_CYCLES = 300;
    localparam int DIM_MAX      = (1 << DIM_W) - 1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic [DIM_W-1:0]    req_width = '0;
    logic [DIM_W-1:0]    req_height = '0;
    logic                empty;
    logic                pop = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page_index;
    logic [DIM_W-1:0]    place_x;
    logic [MARGIN_W-1:0] place_y;
    logic [DIM_W-1:0]    shelf_height;
    logic                opened_shelf;
    logic                opened_page;
    logic                cfg_we = 1'b0;
    logic [MARGIN_W-1:0] cfg_wdata = '0;

    int fail_count;
    int pending;
    int n_placed;
    int n_oversize;
    int n_full;
    int reqs_sent = 0;
    int margin_writes = 0;
    int results_taken = 0;

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    shelf_atlas_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_width    (req_width),
        .req_height   (req_height),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .page_index   (page_index),
        .place_x      (place_x),
        .place_y      (place_y),
        .shelf_height (shelf_height),
        .opened_shelf (opened_shelf),
        .opened_page  (opened_page),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    shelf_atlas_checker atlas_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_width    (req_width),
        .req_height   (req_height),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .page_index   (page_index),
        .place_x      (place_x),
        .place_y      (place_y),
        .shelf_height (shelf_height),
        .opened_shelf (opened_shelf),
        .opened_page  (opened_page),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .n_placed     (n_placed),
        .n_oversize   (n_oversize),
        .n_full       (n_full)
    );

    // offer one request, with random gaps outside the calm window
    task automatic send_req(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        while (!(reqs_sent >= CALM_FROM && reqs_sent < CALM_TO)
               && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req_width <= w;
        req_height <= h;
        @(posedge clk);
        while (full)
            @(posedge clk);
        reqs_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_margin(input logic [MARGIN_W-1:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        margin_writes++;
    endtask

    // mostly ordinary shelf traffic, some zero sizes, width edges and noise
    task automatic send_random(input bit wide_noise);
        int pick;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        pick = $urandom_range(99);
        if (pick < 60) begin
            w = DIM_W'($urandom_range(1, 700));
            h = DIM_W'($urandom_range(1, 24));
        end
        else if (pick < 70) begin
            w = DIM_W'($urandom_range(0, PAGE_WIDTH));
            h = DIM_W'($urandom_range(25, 200));
        end
        else if (pick < 78) begin
            w = DIM_W'($urandom_range(0, PAGE_WIDTH));
            h = DIM_W'($urandom_range(0, 24));
            if ($urandom_range(1))
                w = '0;
            else
                h = '0;
        end
        else if (pick < 85) begin
            w = DIM_W'(PAGE_WIDTH + 1 - int'($urandom_range(0, 4)));
            h = DIM_W'($urandom_range(0, 24));
        end
        else if (wide_noise) begin
            w = DIM_W'($urandom);
            h = DIM_W'($urandom);
        end
        else begin
            // noise that cannot take a page early on
            w = DIM_W'($urandom_range(PAGE_WIDTH + 1, DIM_MAX));
            h = DIM_W'($urandom);
        end
        send_req(w, h);
    endtask

    // result side: random stalls, one long hold-off, a calm stretch
    initial begin
        bit held;
        held = 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (pop && !empty)
                results_taken++;
            if (results_taken == HOLD_AT && !held) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
                pop <= (results_taken >= CALM_FROM && results_taken < CALM_TO)
                       || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // request side and verdict
    initial begin
        int burst;
        int chunk;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        // deepest margin: only zero-height shelves fit, width edges
        set_margin('1);
        send_req('0, '0);
        send_req(DIM_W'(PAGE_WIDTH), '0);
        send_req('0, '0);
        send_req(DIM_W'(1), DIM_W'(1));
        send_req(DIM_W'(PAGE_WIDTH + 1), '0);
        send_req('1, '1);

        // zero margin: height rounding, shelf chaining, exact page-bottom fit
        set_margin('0);
        send_req(DIM_W'(1), DIM_W'(1));
        send_req(DIM_W'(PAGE_WIDTH - 1), DIM_W'(3));
        send_req(DIM_W'(1), DIM_W'(2));
        send_req('0, '0);
        send_req(DIM_W'(PAGE_WIDTH - 1), DIM_W'(4));
        send_req('0, DIM_W'(PAGE_HEIGHT + 1));
        send_req(DIM_W'(PAGE_WIDTH), DIM_W'(PAGE_HEIGHT - 8));

        // zero-height full-width rows push the first pages to their shelf limit
        burst = $urandom_range(100, 140);
        repeat (burst)
            send_req(DIM_W'($urandom_range(1000, PAGE_WIDTH)), '0);

        chunk = (RANDOM_REQS - burst) / 4;
        set_margin(MARGIN_W'($urandom_range(1, 300)));
        repeat (chunk)
            send_random(1'b0);
        set_margin(MARGIN_W'($urandom_range(0, (1 << MARGIN_W) - 1)));
        repeat (chunk)
            send_random(1'b0);
        set_margin('0);
        repeat (chunk)
            send_random(1'b1);
        set_margin(MARGIN_W'($urandom_range(0, (1 << MARGIN_W) - 1)));
        repeat (chunk)
            send_random(1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("summary: %0d requests under %0d top_margin settings", reqs_sent,
                 margin_writes);
        $display("summary: %0d placed, %0d oversize, %0d refused with the atlas full",
                 n_placed, n_oversize, n_full);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hard stop
    initial begin
        #30ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
